/* hdl/icosphere_mesh_subdivider_defines.svh */
// assertion helpers for the subdivider back end (ims_back)
// they expect signals named clk and rst_n in the module that uses them
`ifndef ICOSPHERE_MESH_SUBDIVIDER_DEFINES_SVH
`define ICOSPHERE_MESH_SUBDIVIDER_DEFINES_SVH

// same-cycle implication
`define IMS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IMS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/ims_pkg.sv */
`timescale 1ns / 1ps
package ims_pkg;

  localparam logic [1:0] OP_BUILD = 2'd0;
  localparam logic [1:0] OP_TRI   = 2'd1;
  localparam logic [1:0] OP_VTX   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_LEVEL = 2'd1;
  localparam logic [1:0] ST_INDEX = 2'd2;

  localparam logic [2:0] K_NOP    = 3'd0;
  localparam logic [2:0] K_BUILD  = 3'd1;
  localparam logic [2:0] K_BADLVL = 3'd2;
  localparam logic [2:0] K_TRI    = 3'd3;
  localparam logic [2:0] K_VTX    = 3'd4;

  // width of a cross product or midpoint component fed to the normalizer
  localparam int VW = 33;

  localparam logic signed [15:0] ICO_A = 16'sd8614;
  localparam logic signed [15:0] ICO_B = 16'sd13937;
  localparam logic signed [15:0] Q_ONE = 16'sd16384;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  level;
    logic [12:0] index;
  } cmd_t;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [VW-1:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } pt_t;

  function automatic pt_t base_vtx(input logic [3:0] n);
    pt_t p;
    case (n)
      4'd0:    p = '{-ICO_A, 16'sd0, ICO_B};
      4'd1:    p = '{ICO_A, 16'sd0, ICO_B};
      4'd2:    p = '{-ICO_A, 16'sd0, -ICO_B};
      4'd3:    p = '{ICO_A, 16'sd0, -ICO_B};
      4'd4:    p = '{16'sd0, ICO_B, ICO_A};
      4'd5:    p = '{16'sd0, ICO_B, -ICO_A};
      4'd6:    p = '{16'sd0, -ICO_B, ICO_A};
      4'd7:    p = '{16'sd0, -ICO_B, -ICO_A};
      4'd8:    p = '{ICO_B, ICO_A, 16'sd0};
      4'd9:    p = '{-ICO_B, ICO_A, 16'sd0};
      4'd10:   p = '{ICO_B, -ICO_A, 16'sd0};
      4'd11:   p = '{-ICO_B, -ICO_A, 16'sd0};
      default: p = '0;
    endcase
    return p;
  endfunction

  // corners packed as {a, b, c}
  function automatic logic [11:0] base_tri(input logic [4:0] n);
    logic [11:0] t;
    case (n)
      5'd0:    t = {4'd0, 4'd1, 4'd4};
      5'd1:    t = {4'd0, 4'd4, 4'd9};
      5'd2:    t = {4'd9, 4'd4, 4'd5};
      5'd3:    t = {4'd4, 4'd8, 4'd5};
      5'd4:    t = {4'd4, 4'd1, 4'd8};
      5'd5:    t = {4'd8, 4'd1, 4'd10};
      5'd6:    t = {4'd8, 4'd10, 4'd3};
      5'd7:    t = {4'd5, 4'd8, 4'd3};
      5'd8:    t = {4'd5, 4'd3, 4'd2};
      5'd9:    t = {4'd2, 4'd3, 4'd7};
      5'd10:   t = {4'd7, 4'd3, 4'd10};
      5'd11:   t = {4'd7, 4'd10, 4'd6};
      5'd12:   t = {4'd7, 4'd6, 4'd11};
      5'd13:   t = {4'd11, 4'd6, 4'd0};
      5'd14:   t = {4'd0, 4'd6, 4'd1};
      5'd15:   t = {4'd6, 4'd10, 4'd1};
      5'd16:   t = {4'd9, 4'd11, 4'd0};
      5'd17:   t = {4'd9, 4'd2, 4'd11};
      5'd18:   t = {4'd9, 4'd5, 4'd2};
      5'd19:   t = {4'd7, 4'd11, 4'd2};
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

/* hdl/icosphere_mesh_subdivider.sv */
`timescale 1ns / 1ps
// channel   direction  handshake            payload
// in_       input      in_valid / in_stall  operation, level, index
// out_      output     out_valid / out_stall status, counts, corners, normal, point
//
// a two-entry command queue takes items while the engine works or a result waits
// vertex read: one vertex store read, then the result register; triangle read: time
//   set mostly by the shared normalize unit (32-step square root, three 16-step
//   divides, scale search)
// build: base mesh load, then a split of every triangle per level, three
//   normalizations each
// synchronous reset clears counts and control; the stores need no clearing pass
// a stalled result holds the engine only once it has a new result ready
module icosphere_mesh_subdivider #(
  parameter int MAX_LEVEL   = 4,
  parameter int STORE_SLOTS = 8192
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic [2:0]         in_level,
  input  logic [12:0]        in_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [12:0]        out_triangle_count,
  output logic [12:0]        out_vertex_count,
  output logic [12:0]        out_corner_a,
  output logic [12:0]        out_corner_b,
  output logic [12:0]        out_corner_c,
  output logic signed [15:0] out_normal_x,
  output logic signed [15:0] out_normal_y,
  output logic signed [15:0] out_normal_z,
  output logic signed [15:0] out_point_x,
  output logic signed [15:0] out_point_y,
  output logic signed [15:0] out_point_z
);
  import ims_pkg::*;

  logic q_valid;
  cmd_t q_cmd;
  logic q_take;

  ims_front #(.MAX_LEVEL(MAX_LEVEL), .STORE_SLOTS(STORE_SLOTS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_level     (in_level),
    .in_index     (in_index),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_take       (q_take)
  );

  ims_back #(.STORE_SLOTS(STORE_SLOTS)) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_cmd              (q_cmd),
    .q_take             (q_take),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_triangle_count (out_triangle_count),
    .out_vertex_count   (out_vertex_count),
    .out_corner_a       (out_corner_a),
    .out_corner_b       (out_corner_b),
    .out_corner_c       (out_corner_c),
    .out_normal_x       (out_normal_x),
    .out_normal_y       (out_normal_y),
    .out_normal_z       (out_normal_z),
    .out_point_x        (out_point_x),
    .out_point_y        (out_point_y),
    .out_point_z        (out_point_z)
  );

endmodule

/* hdl/ims_ram.sv */
`timescale 1ns / 1ps
module ims_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/ims_norm.sv */
`timescale 1ns / 1ps
module ims_norm (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  ims_pkg::vec_t vec,
  output logic         busy,
  output logic         done,
  output ims_pkg::pt_t res
);
  import ims_pkg::*;

  localparam logic [2:0] N_IDLE = 3'd0;
  localparam logic [2:0] N_SQ   = 3'd1;
  localparam logic [2:0] N_KS   = 3'd2;
  localparam logic [2:0] N_RT   = 3'd3;
  localparam logic [2:0] N_DS   = 3'd4;
  localparam logic [2:0] N_DQ   = 3'd5;
  localparam logic [2:0] N_DONE = 3'd6;

  logic [2:0]  st_r;
  logic [31:0] mag_r [3];
  logic [2:0]  neg_r;
  logic [1:0]  j_r;
  logic [63:0] sq_r;
  logic [4:0]  k_r;
  logic [63:0] v_r;
  logic [63:0] root_r;
  logic [63:0] bit_r;
  logic [4:0]  cnt_r;
  logic [63:0] rem_r;
  logic [3:0]  qi_r;
  logic [15:0] q_r;
  pt_t         res_r;

  logic [31:0] mag_sel;
  logic [63:0] sqp;
  logic        ks_hit;
  logic [63:0] rt_sum;
  logic        rt_ge;
  logic [63:0] num;
  logic [63:0] dvd;
  logic [63:0] dsh;
  logic        dq_ge;
  logic [15:0] q_cur;
  logic [15:0] q_clamp;
  logic signed [15:0] q_signed;

  function automatic logic [31:0] mag_of(input logic signed [VW-1:0] c);
    logic signed [VW-1:0] a;
    a = c[VW-1] ? -c : c;
    return a[31:0];
  endfunction

  assign mag_sel = mag_r[j_r];
  assign sqp     = 64'(mag_sel) * 64'(mag_sel);
  assign ks_hit  = (sq_r >> (6'd62 - 6'(k_r))) != 64'd0;
  assign rt_sum  = root_r + bit_r;
  assign rt_ge   = v_r >= rt_sum;
  // rounded quotient: (2*num + d) / (2*d)
  assign num     = 64'(mag_sel) << (6'd14 + 6'(k_r[4:1]));
  assign dvd     = {num[62:0], 1'b0} + 64'(root_r[31:0]);
  assign dsh     = 64'({root_r[31:0], 1'b0}) << qi_r;
  assign dq_ge   = rem_r >= dsh;
  assign q_cur   = dq_ge ? (q_r | (16'd1 << qi_r)) : q_r;
  assign q_clamp = (q_cur > 16'(Q_ONE)) ? 16'(Q_ONE) : q_cur;
  assign q_signed = neg_r[j_r] ? -$signed(q_clamp) : $signed(q_clamp);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= N_IDLE;
    end else begin
      case (st_r)
        N_IDLE: begin
          if (start) begin
            mag_r[0] <= mag_of(vec.x);
            mag_r[1] <= mag_of(vec.y);
            mag_r[2] <= mag_of(vec.z);
            neg_r    <= {vec.z[VW-1], vec.y[VW-1], vec.x[VW-1]};
            sq_r     <= '0;
            j_r      <= 2'd0;
            st_r     <= N_SQ;
          end
        end
        N_SQ: begin
          sq_r <= sq_r + sqp;
          if (j_r == 2'd2) begin
            k_r  <= 5'd28;
            st_r <= N_KS;
          end else begin
            j_r <= j_r + 2'd1;
          end
        end
        N_KS: begin
          if (sq_r == 64'd0) begin
            res_r <= '0;
            st_r  <= N_DONE;
          end else if (k_r != 5'd0 && ks_hit) begin
            k_r <= k_r - 5'd2;
          end else begin
            v_r    <= sq_r << k_r;
            root_r <= '0;
            bit_r  <= 64'd1 << 62;
            cnt_r  <= '0;
            st_r   <= N_RT;
          end
        end
        N_RT: begin
          if (rt_ge) begin
            v_r    <= v_r - rt_sum;
            root_r <= (root_r >> 1) + bit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r <= bit_r >> 2;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) begin
            j_r  <= 2'd0;
            st_r <= N_DS;
          end
        end
        N_DS: begin
          rem_r <= dvd;
          q_r   <= '0;
          qi_r  <= 4'd15;
          st_r  <= N_DQ;
        end
        N_DQ: begin
          if (dq_ge) begin
            rem_r <= rem_r - dsh;
          end
          q_r <= q_cur;
          if (qi_r == 4'd0) begin
            case (j_r)
              2'd0:    res_r.x <= q_signed;
              2'd1:    res_r.y <= q_signed;
              default: res_r.z <= q_signed;
            endcase
            if (j_r == 2'd2) begin
              st_r <= N_DONE;
            end else begin
              j_r  <= j_r + 2'd1;
              st_r <= N_DS;
            end
          end else begin
            qi_r <= qi_r - 4'd1;
          end
        end
        N_DONE: begin
          st_r <= N_IDLE;
        end
        default: begin
          st_r <= N_IDLE;
        end
      endcase
    end
  end

  assign busy = st_r != N_IDLE;
  assign done = st_r == N_DONE;
  assign res  = res_r;

endmodule

/* hdl/ims_front.sv */
`timescale 1ns / 1ps
module ims_front #(
  parameter int MAX_LEVEL   = 4,
  parameter int STORE_SLOTS = 8192
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    in_operation,
  input  logic [2:0]    in_level,
  input  logic [12:0]   in_index,
  output logic          q_valid,
  output ims_pkg::cmd_t q_cmd,
  input  logic          q_take
);
  import ims_pkg::*;

  cmd_t       ent_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       lvl_ok;
  logic       push;
  cmd_t       cmd;

  // a build fits when its level is at most MAX_LEVEL and its final triangle count stays within the store
  assign lvl_ok = (32'(in_level) <= 32'(MAX_LEVEL)) &&
                  ((32'd20 << {in_level, 1'b0}) <= 32'(STORE_SLOTS));

  always_comb begin
    cmd.level = in_level;
    cmd.index = in_index;
    case (in_operation)
      OP_BUILD: cmd.kind = lvl_ok ? K_BUILD : K_BADLVL;
      OP_TRI:   cmd.kind = K_TRI;
      OP_VTX:   cmd.kind = K_VTX;
      default:  cmd.kind = K_NOP;
    endcase
  end

  assign in_stall = cnt_r == 2'd2;
  assign push     = in_valid && !in_stall;
  assign q_valid  = cnt_r != 2'd0;
  assign q_cmd    = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= cmd;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (q_take) begin
        rp_r <= ~rp_r;
      end
      case ({push, q_take})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

/* hdl/ims_back.sv */
`timescale 1ns / 1ps
`include "icosphere_mesh_subdivider_defines.svh"
module ims_back #(
  parameter int STORE_SLOTS = 8192
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  ims_pkg::cmd_t      q_cmd,
  output logic               q_take,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [12:0]        out_triangle_count,
  output logic [12:0]        out_vertex_count,
  output logic [12:0]        out_corner_a,
  output logic [12:0]        out_corner_b,
  output logic [12:0]        out_corner_c,
  output logic signed [15:0] out_normal_x,
  output logic signed [15:0] out_normal_y,
  output logic signed [15:0] out_normal_z,
  output logic signed [15:0] out_point_x,
  output logic signed [15:0] out_point_y,
  output logic signed [15:0] out_point_z
);
  import ims_pkg::*;

  localparam int AW = $clog2(STORE_SLOTS);
  localparam int CW = $clog2(STORE_SLOTS + 1);
  localparam int LW = (CW > 13) ? CW : 13;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_BASE  = 4'd1;
  localparam logic [3:0] S_SPLIT = 4'd2;
  localparam logic [3:0] S_TW    = 4'd3;
  localparam logic [3:0] S_TG    = 4'd4;
  localparam logic [3:0] S_VW    = 4'd5;
  localparam logic [3:0] S_VG    = 4'd6;
  localparam logic [3:0] S_MS    = 4'd7;
  localparam logic [3:0] S_MW    = 4'd8;
  localparam logic [3:0] S_TWR   = 4'd9;
  localparam logic [3:0] S_UV    = 4'd10;
  localparam logic [3:0] S_CROSS = 4'd11;
  localparam logic [3:0] S_NS    = 4'd12;
  localparam logic [3:0] S_NW    = 4'd13;
  localparam logic [3:0] S_OUT   = 4'd14;

  localparam logic [1:0] MD_NONE  = 2'd0;
  localparam logic [1:0] MD_BUILD = 2'd1;
  localparam logic [1:0] MD_TRI   = 2'd2;
  localparam logic [1:0] MD_VTX   = 2'd3;

  logic [3:0]    st_r;
  logic [1:0]    mode_r;
  logic [1:0]    stat_r;
  logic [2:0]    step_r;
  logic [CW-1:0] i_r;
  logic [CW-1:0] t_r;
  logic [CW-1:0] tri_cnt_r;
  logic [CW-1:0] vtx_cnt_r;
  logic [AW-1:0] taddr_r;
  logic [AW-1:0] vaddr_r;
  logic [AW-1:0] ca_r;
  logic [AW-1:0] cb_r;
  logic [AW-1:0] cc_r;
  logic [AW-1:0] m_r [3];
  pt_t           pa_r;
  pt_t           pb_r;
  pt_t           pc_r;
  logic signed [16:0] ux_r, uy_r, uz_r, vx_r, vy_r, vz_r;
  vec_t          c_r;
  logic [2:0]    xs_r;
  logic [1:0]    vsel_r;
  logic [1:0]    msel_r;
  logic [1:0]    wsel_r;

  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [12:0]   out_tcnt_r;
  logic [12:0]   out_vcnt_r;
  logic [12:0]   out_ca_r;
  logic [12:0]   out_cb_r;
  logic [12:0]   out_cc_r;
  pt_t           out_n_r;
  pt_t           out_p_r;

  // stores
  logic            vram_we;
  logic [AW-1:0]   vram_waddr;
  pt_t             vram_wdata;
  logic [47:0]     vram_rdata;
  pt_t             vrd;
  logic            tram_we;
  logic [AW-1:0]   tram_waddr;
  logic [3*AW-1:0] tram_wdata;
  logic [3*AW-1:0] tram_rdata;
  logic [AW-1:0]   trd_a, trd_b, trd_c;
  logic [11:0]     btri;

  // normalizer
  logic  norm_start;
  vec_t  norm_vec;
  logic  norm_busy;
  logic  norm_done;
  pt_t   norm_res;
  vec_t  mid_vec;
  pt_t   mid_p, mid_q;

  logic signed [16:0] mul_a, mul_b;
  logic signed [33:0] prod;
  logic signed [VW-1:0] prod_n;
  logic [LW-1:0] idx_ext;
  logic          can_load;
  logic [CW-1:0] nt4;
  logic          last_tri;

  ims_ram #(.WIDTH(48), .DEPTH(STORE_SLOTS)) u_vram (
    .clk   (clk),
    .we    (vram_we),
    .waddr (vram_waddr),
    .wdata (vram_wdata),
    .raddr (vaddr_r),
    .rdata (vram_rdata)
  );

  ims_ram #(.WIDTH(3 * AW), .DEPTH(STORE_SLOTS)) u_tram (
    .clk   (clk),
    .we    (tram_we),
    .waddr (tram_waddr),
    .wdata (tram_wdata),
    .raddr (taddr_r),
    .rdata (tram_rdata)
  );

  ims_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (norm_start),
    .vec   (norm_vec),
    .busy  (norm_busy),
    .done  (norm_done),
    .res   (norm_res)
  );

  assign vrd   = vram_rdata;
  assign trd_a = tram_rdata[3*AW-1:2*AW];
  assign trd_b = tram_rdata[2*AW-1:AW];
  assign trd_c = tram_rdata[AW-1:0];
  assign btri  = base_tri(i_r[4:0]);

  // vertex store writes: base load, then one per finished midpoint
  always_comb begin
    vram_we    = 1'b0;
    vram_waddr = vtx_cnt_r[AW-1:0];
    vram_wdata = norm_res;
    if (st_r == S_BASE) begin
      vram_we    = i_r < CW'(12);
      vram_waddr = i_r[AW-1:0];
      vram_wdata = base_vtx(i_r[3:0]);
    end else if (st_r == S_MW) begin
      vram_we = norm_done;
    end
  end

  // triangle store writes: base load; when splitting, three new triangles at the end, then source in place
  always_comb begin
    tram_we    = 1'b0;
    tram_waddr = i_r[AW-1:0];
    tram_wdata = {ca_r, m_r[0], m_r[2]};
    if (st_r == S_BASE) begin
      tram_we    = 1'b1;
      tram_wdata = {AW'(btri[11:8]), AW'(btri[7:4]), AW'(btri[3:0])};
    end else if (st_r == S_TWR) begin
      tram_we = 1'b1;
      case (wsel_r)
        2'd0: begin
          tram_waddr = t_r[AW-1:0];
          tram_wdata = {m_r[0], m_r[1], m_r[2]};
        end
        2'd1: begin
          tram_waddr = t_r[AW-1:0] + AW'(1);
          tram_wdata = {m_r[0], cb_r, m_r[1]};
        end
        2'd2: begin
          tram_waddr = t_r[AW-1:0] + AW'(2);
          tram_wdata = {m_r[1], cc_r, m_r[2]};
        end
        default: begin
          tram_waddr = i_r[AW-1:0];
          tram_wdata = {ca_r, m_r[0], m_r[2]};
        end
      endcase
    end
  end

  // midpoint direction is the unhalved sum of two corners
  always_comb begin
    case (msel_r)
      2'd0: begin
        mid_p = pa_r;
        mid_q = pb_r;
      end
      2'd1: begin
        mid_p = pb_r;
        mid_q = pc_r;
      end
      default: begin
        mid_p = pc_r;
        mid_q = pa_r;
      end
    endcase
    mid_vec.x = VW'(17'(mid_p.x) + 17'(mid_q.x));
    mid_vec.y = VW'(17'(mid_p.y) + 17'(mid_q.y));
    mid_vec.z = VW'(17'(mid_p.z) + 17'(mid_q.z));
  end

  assign norm_start = (st_r == S_MS) || (st_r == S_NS);
  assign norm_vec   = (st_r == S_NS) ? c_r : mid_vec;

  // cross product: one product per cycle, pairs subtracted
  always_comb begin
    case (xs_r)
      3'd0:    begin mul_a = uy_r; mul_b = vz_r; end
      3'd1:    begin mul_a = uz_r; mul_b = vy_r; end
      3'd2:    begin mul_a = uz_r; mul_b = vx_r; end
      3'd3:    begin mul_a = ux_r; mul_b = vz_r; end
      3'd4:    begin mul_a = ux_r; mul_b = vy_r; end
      default: begin mul_a = uy_r; mul_b = vx_r; end
    endcase
  end

  assign prod   = mul_a * mul_b;
  assign prod_n = prod[VW-1:0];

  assign idx_ext  = LW'(q_cmd.index);
  assign q_take   = (st_r == S_IDLE) && q_valid;
  assign can_load = !out_valid_r || !out_stall;
  assign nt4      = {tri_cnt_r[CW-3:0], 2'b00};
  assign last_tri = (i_r + CW'(1)) == tri_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      tri_cnt_r   <= '0;
      vtx_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (st_r == S_OUT && can_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (st_r)
        S_IDLE: begin
          if (q_valid) begin
            stat_r <= ST_OK;
            mode_r <= MD_NONE;
            case (q_cmd.kind)
              K_BUILD: begin
                step_r <= q_cmd.level;
                i_r    <= '0;
                mode_r <= MD_BUILD;
                st_r   <= S_BASE;
              end
              K_BADLVL: begin
                stat_r <= ST_LEVEL;
                st_r   <= S_OUT;
              end
              K_TRI: begin
                if (idx_ext >= LW'(tri_cnt_r)) begin
                  stat_r <= ST_INDEX;
                  st_r   <= S_OUT;
                end else begin
                  taddr_r <= AW'(q_cmd.index);
                  mode_r  <= MD_TRI;
                  st_r    <= S_TW;
                end
              end
              K_VTX: begin
                if (idx_ext >= LW'(vtx_cnt_r)) begin
                  stat_r <= ST_INDEX;
                  st_r   <= S_OUT;
                end else begin
                  vaddr_r <= AW'(q_cmd.index);
                  vsel_r  <= 2'd2;
                  mode_r  <= MD_VTX;
                  st_r    <= S_VW;
                end
              end
              default: begin
                st_r <= S_OUT;
              end
            endcase
          end
        end
        S_BASE: begin
          if (i_r == CW'(19)) begin
            tri_cnt_r <= CW'(20);
            vtx_cnt_r <= CW'(12);
            if (step_r == 3'd0) begin
              st_r <= S_OUT;
            end else begin
              i_r  <= '0;
              t_r  <= CW'(20);
              st_r <= S_SPLIT;
            end
          end else begin
            i_r <= i_r + CW'(1);
          end
        end
        S_SPLIT: begin
          taddr_r <= i_r[AW-1:0];
          st_r    <= S_TW;
        end
        S_TW: begin
          st_r <= S_TG;
        end
        S_TG: begin
          ca_r    <= trd_a;
          cb_r    <= trd_b;
          cc_r    <= trd_c;
          vaddr_r <= trd_a;
          vsel_r  <= 2'd0;
          st_r    <= S_VW;
        end
        S_VW: begin
          st_r <= S_VG;
        end
        S_VG: begin
          case (vsel_r)
            2'd0: begin
              pa_r    <= vrd;
              vaddr_r <= cb_r;
            end
            2'd1: begin
              pb_r    <= vrd;
              vaddr_r <= cc_r;
            end
            default: begin
              pc_r <= vrd;
            end
          endcase
          if (vsel_r != 2'd2) begin
            vsel_r <= vsel_r + 2'd1;
            st_r   <= S_VW;
          end else begin
            case (mode_r)
              MD_BUILD: begin
                msel_r <= 2'd0;
                st_r   <= S_MS;
              end
              MD_TRI:  st_r <= S_UV;
              default: st_r <= S_OUT;
            endcase
          end
        end
        S_MS: begin
          st_r <= S_MW;
        end
        S_MW: begin
          if (norm_done) begin
            m_r[msel_r] <= vtx_cnt_r[AW-1:0];
            vtx_cnt_r   <= vtx_cnt_r + CW'(1);
            if (msel_r == 2'd2) begin
              wsel_r <= 2'd0;
              st_r   <= S_TWR;
            end else begin
              msel_r <= msel_r + 2'd1;
              st_r   <= S_MS;
            end
          end
        end
        S_TWR: begin
          if (wsel_r == 2'd3) begin
            t_r <= t_r + CW'(3);
            if (last_tri) begin
              // pass done: the list has grown fourfold
              tri_cnt_r <= nt4;
              step_r    <= step_r - 3'd1;
              if (step_r == 3'd1) begin
                st_r <= S_OUT;
              end else begin
                i_r  <= '0;
                t_r  <= nt4;
                st_r <= S_SPLIT;
              end
            end else begin
              i_r  <= i_r + CW'(1);
              st_r <= S_SPLIT;
            end
          end else begin
            wsel_r <= wsel_r + 2'd1;
          end
        end
        S_UV: begin
          ux_r <= 17'(pb_r.x) - 17'(pa_r.x);
          uy_r <= 17'(pb_r.y) - 17'(pa_r.y);
          uz_r <= 17'(pb_r.z) - 17'(pa_r.z);
          vx_r <= 17'(pc_r.x) - 17'(pa_r.x);
          vy_r <= 17'(pc_r.y) - 17'(pa_r.y);
          vz_r <= 17'(pc_r.z) - 17'(pa_r.z);
          xs_r <= 3'd0;
          st_r <= S_CROSS;
        end
        S_CROSS: begin
          case (xs_r[2:1])
            2'd0:    c_r.x <= xs_r[0] ? c_r.x - prod_n : prod_n;
            2'd1:    c_r.y <= xs_r[0] ? c_r.y - prod_n : prod_n;
            default: c_r.z <= xs_r[0] ? c_r.z - prod_n : prod_n;
          endcase
          if (xs_r == 3'd5) begin
            st_r <= S_NS;
          end else begin
            xs_r <= xs_r + 3'd1;
          end
        end
        S_NS: begin
          st_r <= S_NW;
        end
        S_NW: begin
          if (norm_done) begin
            st_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (can_load) begin
            st_r <= S_IDLE;
          end
        end
        default: begin
          st_r <= S_IDLE;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (st_r == S_OUT && can_load) begin
      out_status_r <= stat_r;
      out_tcnt_r   <= 13'(tri_cnt_r);
      out_vcnt_r   <= 13'(vtx_cnt_r);
      out_ca_r     <= (mode_r == MD_TRI) ? 13'(ca_r) : 13'd0;
      out_cb_r     <= (mode_r == MD_TRI) ? 13'(cb_r) : 13'd0;
      out_cc_r     <= (mode_r == MD_TRI) ? 13'(cc_r) : 13'd0;
      out_n_r      <= (mode_r == MD_TRI) ? norm_res : '0;
      out_p_r      <= (mode_r == MD_VTX) ? pc_r : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_triangle_count = out_tcnt_r;
  assign out_vertex_count   = out_vcnt_r;
  assign out_corner_a       = out_ca_r;
  assign out_corner_b       = out_cb_r;
  assign out_corner_c       = out_cc_r;
  assign out_normal_x       = out_n_r.x;
  assign out_normal_y       = out_n_r.y;
  assign out_normal_z       = out_n_r.z;
  assign out_point_x        = out_p_r.x;
  assign out_point_y        = out_p_r.y;
  assign out_point_z        = out_p_r.z;

  `IMS_ASSERT_IMP(a_count_link, (st_r == S_IDLE && tri_cnt_r != '0), (vtx_cnt_r + CW'(8) == tri_cnt_r), "vertex and triangle counts disagree")
  `IMS_ASSERT_IMP(a_start_free, norm_start, !norm_busy, "normalizer started while busy")
  `IMS_ASSERT_NXT(a_norm_runs, (st_r == S_MS || st_r == S_NS), norm_busy, "normalizer did not start")
  `IMS_ASSERT_IMP(a_vtx_bound, (st_r == S_MW && norm_done), (vtx_cnt_r < CW'(STORE_SLOTS)), "midpoint written past store")

endmodule

/* bench/icosphere_mesh_checker.sv */
`timescale 1ns / 1ps
module icosphere_mesh_checker
  import ims_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic [2:0]         in_level,
  input  logic [12:0]        in_index,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         out_status,
  input  logic [12:0]        out_triangle_count,
  input  logic [12:0]        out_vertex_count,
  input  logic [12:0]        out_corner_a,
  input  logic [12:0]        out_corner_b,
  input  logic [12:0]        out_corner_c,
  input  logic signed [15:0] out_normal_x,
  input  logic signed [15:0] out_normal_y,
  input  logic signed [15:0] out_normal_z,
  input  logic signed [15:0] out_point_x,
  input  logic signed [15:0] out_point_y,
  input  logic signed [15:0] out_point_z,
  output int                 errors,
  output int                 pending
);

  localparam int MAX_LVL = 4;
  localparam int SLOTS   = 8192;

  typedef struct {
    logic [1:0]         status;
    logic [12:0]        tri_cnt;
    logic [12:0]        vtx_cnt;
    logic [12:0]        ca, cb, cc;
    logic signed [15:0] nx, ny, nz;
    logic signed [15:0] px, py, pz;
  } mesh_result_t;

  mesh_result_t answers_due[$];

  pt_t         mesh_pts[SLOTS];
  logic [12:0] mesh_tris[SLOTS][3];
  int          n_pts;
  int          n_tris;

  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic pt_t unit_vec(input longint cx, input longint cy, input longint cz);
    longint      c[3];
    logic [63:0] mag[3];
    logic [63:0] sq;
    logic [63:0] d;
    logic [63:0] q;
    int          k;
    logic signed [15:0] o[3];
    pt_t         p;
    c[0] = cx;
    c[1] = cy;
    c[2] = cz;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = c[i] < 0 ? -c[i] : c[i];
      sq = sq + mag[i] * mag[i];
    end
    if (sq == 0) return '0;
    k = 28;
    while (k > 0 && (sq >> (62 - k)) != 0) k -= 2;
    d = root64(sq << k);
    for (int i = 0; i < 3; i++) begin
      q = (2 * (mag[i] << (14 + k / 2)) + d) / (2 * d);
      if (q > 16384) q = 16384;
      o[i] = c[i] < 0 ? -$signed(q[15:0]) : $signed(q[15:0]);
    end
    p.x = o[0];
    p.y = o[1];
    p.z = o[2];
    return p;
  endfunction

  function automatic int add_mid(input int a, input int b);
    add_mid = n_pts;
    mesh_pts[n_pts] = unit_vec(longint'(mesh_pts[a].x) + mesh_pts[b].x,
                               longint'(mesh_pts[a].y) + mesh_pts[b].y,
                               longint'(mesh_pts[a].z) + mesh_pts[b].z);
    n_pts++;
  endfunction

  function automatic void set_tri(input int t, input int a, input int b, input int c);
    mesh_tris[t][0] = 13'(a);
    mesh_tris[t][1] = 13'(b);
    mesh_tris[t][2] = 13'(c);
  endfunction

  function automatic void subdivide(input int lvl);
    logic [11:0] bt;
    int nt, a, b, c, m0, m1, m2;
    for (int i = 0; i < 12; i++) mesh_pts[i] = base_vtx(4'(i));
    for (int i = 0; i < 20; i++) begin
      bt = base_tri(5'(i));
      set_tri(i, int'(bt[11:8]), int'(bt[7:4]), int'(bt[3:0]));
    end
    n_pts = 12;
    n_tris = 20;
    for (int s = 0; s < lvl; s++) begin
      nt = 20 << (2 * s);
      for (int i = 0; i < nt; i++) begin
        a = mesh_tris[i][0];
        b = mesh_tris[i][1];
        c = mesh_tris[i][2];
        m0 = add_mid(a, b);
        m1 = add_mid(b, c);
        m2 = add_mid(c, a);
        set_tri(nt + 3 * i, m0, m1, m2);
        set_tri(nt + 3 * i + 1, m0, b, m1);
        set_tri(nt + 3 * i + 2, m1, c, m2);
        set_tri(i, a, m0, m2);
      end
      n_tris = nt * 4;
    end
  endfunction

  function automatic mesh_result_t mesh_answer(input logic [1:0] op, input logic [2:0] lvl,
                                               input logic [12:0] idx);
    mesh_result_t r;
    pt_t pa, pb, pc, n;
    longint u[3], v[3];
    r = '{default: '0};
    r.status = ST_OK;
    if (op == OP_BUILD) begin
      if (lvl > MAX_LVL || (20 << (2 * lvl)) > SLOTS) r.status = ST_LEVEL;
      else subdivide(int'(lvl));
    end else if (op == OP_TRI) begin
      if (idx >= n_tris) begin
        r.status = ST_INDEX;
      end else begin
        r.ca = mesh_tris[idx][0];
        r.cb = mesh_tris[idx][1];
        r.cc = mesh_tris[idx][2];
        pa = mesh_pts[r.ca];
        pb = mesh_pts[r.cb];
        pc = mesh_pts[r.cc];
        u[0] = longint'(pb.x) - pa.x;
        u[1] = longint'(pb.y) - pa.y;
        u[2] = longint'(pb.z) - pa.z;
        v[0] = longint'(pc.x) - pa.x;
        v[1] = longint'(pc.y) - pa.y;
        v[2] = longint'(pc.z) - pa.z;
        n = unit_vec(u[1] * v[2] - u[2] * v[1], u[2] * v[0] - u[0] * v[2],
                     u[0] * v[1] - u[1] * v[0]);
        r.nx = n.x;
        r.ny = n.y;
        r.nz = n.z;
      end
    end else if (op == OP_VTX) begin
      if (idx >= n_pts) begin
        r.status = ST_INDEX;
      end else begin
        r.px = mesh_pts[idx].x;
        r.py = mesh_pts[idx].y;
        r.pz = mesh_pts[idx].z;
      end
    end
    r.tri_cnt = 13'(n_tris);
    r.vtx_cnt = 13'(n_pts);
    return r;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  initial begin
    errors = 0;
    n_pts = 0;
    n_tris = 0;
  end

  assign pending = answers_due.size();

  always @(posedge clk) begin
    mesh_result_t e;
    if (rst_n) begin
      if (in_valid && !in_stall) answers_due.push_back(mesh_answer(in_operation, in_level,
                                                                   in_index));
      if (out_valid && !out_stall) begin
        if (answers_due.size() == 0) begin
          $display("%0t result transfer with nothing expected", $time);
          errors++;
        end else begin
          e = answers_due.pop_front();
          check_field("status", e.status, out_status);
          check_field("triangle_count", e.tri_cnt, out_triangle_count);
          check_field("vertex_count", e.vtx_cnt, out_vertex_count);
          check_field("corner_a", e.ca, out_corner_a);
          check_field("corner_b", e.cb, out_corner_b);
          check_field("corner_c", e.cc, out_corner_c);
          check_field("normal_x", e.nx, out_normal_x);
          check_field("normal_y", e.ny, out_normal_y);
          check_field("normal_z", e.nz, out_normal_z);
          check_field("point_x", e.px, out_point_x);
          check_field("point_y", e.py, out_point_y);
          check_field("point_z", e.pz, out_point_z);
        end
      end
    end
  end

endmodule

/* bench/icosphere_mesh_subdivider_tb.sv */
`timescale 1ns / 1ps
module icosphere_mesh_subdivider_tb;
  import ims_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_operation = OP_NONE;
  logic [2:0]         in_level = '0;
  logic [12:0]        in_index = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_status;
  logic [12:0]        out_triangle_count, out_vertex_count;
  logic [12:0]        out_corner_a, out_corner_b, out_corner_c;
  logic signed [15:0] out_normal_x, out_normal_y, out_normal_z;
  logic signed [15:0] out_point_x, out_point_y, out_point_z;
  int                 errors;
  int                 pending;

  int idle_pct = 0;
  int stall_pct = 0;
  int tri_total = 0;
  int pt_total = 0;

  always #5 clk = ~clk;

  icosphere_mesh_subdivider dut (.*);

  icosphere_mesh_checker chk (.*);

  always @(posedge clk) out_stall <= $urandom_range(99) < stall_pct;

  task automatic send(input logic [1:0] op, input logic [2:0] lvl, input logic [12:0] idx);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_level <= lvl;
    in_index <= idx;
    // stimulus-side view of mesh size, used only to aim read indices
    if (op == OP_BUILD && lvl <= 4) begin
      tri_total = 20 << (2 * lvl);
      pt_total = 12 + 3 * ((20 << (2 * lvl)) - 20) / 3;
    end
    do @(posedge clk); while (in_stall);
  endtask

  task automatic random_items(input int n);
    int r;
    logic [12:0] idx;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 2) begin
        r = $urandom_range(15);
        send(OP_BUILD, r < 7 ? 3'd0 : r < 12 ? 3'd1 : r < 13 ? 3'd2 : 3'($urandom_range(5, 7)),
             13'($urandom));
      end else if (r < 5) begin
        send(OP_NONE, 3'($urandom), 13'($urandom));
      end else begin
        if ($urandom_range(9) < 8 && tri_total > 0)
          idx = r < 50 ? 13'($urandom_range(tri_total - 1)) : 13'($urandom_range(pt_total - 1));
        else
          idx = 13'($urandom);
        send(r < 50 ? OP_TRI : OP_VTX, 3'($urandom), idx);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // reads before any build, unused operation, oversized levels
    send(OP_TRI, 3'd0, 13'd0);
    send(OP_VTX, 3'd0, 13'd0);
    send(OP_NONE, 3'd7, 13'd8191);
    send(OP_BUILD, 3'd5, 13'd0);
    send(OP_BUILD, 3'd7, 13'd8191);
    send(OP_BUILD, 3'd0, 13'd0);
    send(OP_TRI, 3'd0, 13'd0);
    send(OP_TRI, 3'd7, 13'd19);
    send(OP_TRI, 3'd0, 13'd20);
    send(OP_VTX, 3'd0, 13'd0);
    send(OP_VTX, 3'd0, 13'd11);
    send(OP_VTX, 3'd7, 13'd12);
    send(OP_TRI, 3'd7, 13'd8191);
    send(OP_BUILD, 3'd1, 13'd0);
    send(OP_TRI, 3'd0, 13'd79);
    send(OP_VTX, 3'd0, 13'd71);
    send(OP_BUILD, 3'd4, 13'd0);
    send(OP_TRI, 3'd0, 13'd5119);
    send(OP_VTX, 3'd0, 13'd5111);
    send(OP_TRI, 3'd0, 13'd5120);
    send(OP_VTX, 3'd0, 13'd5112);
    send(OP_BUILD, 3'd6, 13'd0);
    send(OP_NONE, 3'd2, 13'd4096);
    random_items(350);
    idle_pct = 86;
    random_items(350);
    idle_pct = 0;
    stall_pct = 86;
    send(OP_BUILD, 3'd3, 13'd0);
    random_items(350);
    idle_pct = 24;
    stall_pct = 24;
    send(OP_BUILD, 3'd2, 13'd0);
    random_items(350);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #100_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
